>>> design/udrf_pkg.sv
// Package for the dual ring FIFO block: opcodes, status codes, depth default
// and the control struct between the top level and each cell chain.
// No dependencies.
`default_nettype none

package udrf_pkg;

    localparam int unsigned UDRF_DEPTH = (1 << 6);

    typedef enum logic [2:0] {
        OP_RX_ARRIVE = 3'd0,
        OP_RX_POP    = 3'd1,
        OP_RX_PEEK   = 3'd2,
        OP_TX_PUSH   = 3'd3,
        OP_TX_TAKE   = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

`default_nettype wire

>>> design/udrf_cell.sv
// One byte cell of a shift-down FIFO chain.
// Loads a new byte, takes its upper neighbour's byte, or holds.
`default_nettype none

module udrf_cell (
    input  wire logic       aclk,
    input  wire logic       load,
    input  wire logic       shift,
    input  wire logic [7:0] load_data,
    input  wire logic [7:0] shift_data,
    output logic [7:0]      data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (load) begin
            data_next = load_data;
        end else if (shift) begin
            data_next = shift_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> design/udrf_chain.sv
// One FIFO built as a row of udrf_cell with a fill counter; the head is cell 0.
// Depends on udrf_pkg and udrf_cell. Push and pop never arrive together.
`default_nettype none

module udrf_chain
    import udrf_pkg::*;
#(
    parameter int unsigned DEPTH   = UDRF_DEPTH,
    parameter int unsigned LEVEL_W = $clog2(DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fifo_ctrl_t         ctrl,
    input  wire logic [7:0]         wr_data,
    output logic [7:0]              head_data,
    output logic [LEVEL_W-1:0]      fill,
    output logic [LEVEL_W-1:0]      fill_next
);

    logic [LEVEL_W-1:0] fill_reg;
    logic [7:0]         cell_data [DEPTH];

    always_comb begin
        fill_next = fill_reg;
        if (ctrl.push) begin
            fill_next = fill_reg + LEVEL_W'(1);
        end else if (ctrl.pop) begin
            fill_next = fill_reg - LEVEL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [7:0] upper;
        if (i == DEPTH - 1) begin : g_last
            assign upper = cell_data[i];
        end else begin : g_mid
            assign upper = cell_data[i+1];
        end

        udrf_cell u_cell (
            .aclk       (aclk),
            .load       (ctrl.push && (fill_reg == LEVEL_W'(i))),
            .shift      (ctrl.pop),
            .load_data  (wr_data),
            .shift_data (upper),
            .data       (cell_data[i])
        );
    end

    assign head_data = cell_data[0];
    assign fill      = fill_reg;

endmodule

`default_nettype wire

>>> design/uart_dual_ring_fifo.sv
// Top level of the dual UART FIFO: receive and transmit chains, opcode decode
// and the result register. Depends on udrf_pkg and udrf_chain.
//
// Each transfer on the s_ side is decoded combinationally; its single result is
// held in an output register, so a new item is taken every cycle while m_ready
// is high; the result appears in the cycle after the transfer. Each FIFO is a
// shift-down row of DEPTH byte cells, so a pop moves every cell one place and
// a push writes the cell at the fill count; the decode plus one count update
// per cycle sets the one-item-per-cycle rate. No clearing pass after reset.
`default_nettype none

module uart_dual_ring_fifo
    import udrf_pkg::*;
#(
    parameter int unsigned DEPTH   = UDRF_DEPTH,
    parameter int unsigned LEVEL_W = $clog2(DEPTH + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_opcode,
    input  wire logic [7:0]         s_data_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_data_out,
    output logic                    m_data_valid,
    output logic [1:0]              m_status,
    output logic [LEVEL_W-1:0]      m_rx_level,
    output logic [LEVEL_W-1:0]      m_tx_level,
    output logic                    m_tx_irq_enable
);

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(DEPTH);

    fifo_ctrl_t         rx_ctrl;
    fifo_ctrl_t         tx_ctrl;
    logic [7:0]         rx_head;
    logic [7:0]         tx_head;
    logic [LEVEL_W-1:0] rx_fill;
    logic [LEVEL_W-1:0] tx_fill;
    logic [LEVEL_W-1:0] rx_fill_next;
    logic [LEVEL_W-1:0] tx_fill_next;

    logic               accept;
    logic [7:0]         dout;
    logic               dvalid;
    status_t            status;

    logic               irq_reg;
    logic               irq_next;
    logic               m_valid_reg;
    logic [7:0]         m_data_out_reg;
    logic               m_data_valid_reg;
    logic [1:0]         m_status_reg;
    logic [LEVEL_W-1:0] m_rx_level_reg;
    logic [LEVEL_W-1:0] m_tx_level_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        rx_ctrl  = '0;
        tx_ctrl  = '0;
        dout     = '0;
        dvalid   = 1'b0;
        status   = ST_OK;
        irq_next = irq_reg;
        if (accept) begin
            unique case (opcode_t'(s_opcode))
                OP_RX_ARRIVE: begin
                    if (rx_fill == FULL_LEVEL) begin
                        status = ST_DROPPED;
                    end else begin
                        rx_ctrl.push = 1'b1;
                    end
                end
                OP_RX_POP, OP_RX_PEEK: begin
                    if (rx_fill == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        dout        = rx_head;
                        dvalid      = 1'b1;
                        rx_ctrl.pop = (opcode_t'(s_opcode) == OP_RX_POP);
                    end
                end
                OP_TX_PUSH: begin
                    if (tx_fill == FULL_LEVEL) begin
                        status = ST_FULL;
                    end else begin
                        tx_ctrl.push = 1'b1;
                        irq_next     = 1'b1;
                    end
                end
                OP_TX_TAKE: begin
                    if (tx_fill == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        dout        = tx_head;
                        dvalid      = 1'b1;
                        tx_ctrl.pop = 1'b1;
                    end
                    if (tx_fill <= LEVEL_W'(1)) begin
                        irq_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    udrf_chain #(
        .DEPTH   (DEPTH),
        .LEVEL_W (LEVEL_W)
    ) u_rx_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rx_ctrl),
        .wr_data   (s_data_in),
        .head_data (rx_head),
        .fill      (rx_fill),
        .fill_next (rx_fill_next)
    );

    udrf_chain #(
        .DEPTH   (DEPTH),
        .LEVEL_W (LEVEL_W)
    ) u_tx_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tx_ctrl),
        .wr_data   (s_data_in),
        .head_data (tx_head),
        .fill      (tx_fill),
        .fill_next (tx_fill_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            irq_reg <= irq_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_out_reg   <= dout;
            m_data_valid_reg <= dvalid;
            m_status_reg     <= status;
            m_rx_level_reg   <= rx_fill_next;
            m_tx_level_reg   <= tx_fill_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data_out      = m_data_out_reg;
    assign m_data_valid    = m_data_valid_reg;
    assign m_status        = m_status_reg;
    assign m_rx_level      = m_rx_level_reg;
    assign m_tx_level      = m_tx_level_reg;
    assign m_tx_irq_enable = irq_reg;

endmodule

`default_nettype wire
